[hw/rtl/rgbcrop_pkg.sv]
// shared constants and types of the 24-bit row-padded crop block
`timescale 1ns / 1ps
`default_nettype none
package rgbcrop_pkg;

  // widest source row that the position counter is sized for, in pixels
  localparam int unsigned MaxWidth = 4096;

  // field and register widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned DimW     = 13;
  localparam int unsigned OffW     = 12;
  localparam int unsigned PosW     = 14;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcWidth  = 3'd0,
    CfgSrcHeight = 3'd1,
    CfgCropX     = 3'd2,
    CfgCropY     = 3'd3,
    CfgCropW     = 3'd4,
    CfgCropH     = 3'd5
  } cfg_reg_e;

  // one kept byte waiting for the output side, with its trailing padding
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             row_last;
    logic [1:0]       pad;
    logic             img_row;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/rgb24_row_padded_crop.sv]
// window crop of a 24-bit pixel byte stream with row padding on both sides
`timescale 1ns / 1ps
`default_nettype none
// Takes one source byte per cycle and gives zero or one kept byte, followed
// after the last kept byte of each row by up to three zero padding words, so
// that every output row is a multiple of four bytes. A byte is accepted in
// every cycle while the output side keeps up; a row-end byte holds the
// output register until the last of its padding words has been taken, and the
// input waits only for that drain. Position and row counters are updated as
// each byte is accepted; start_of_image clears them for that byte. The
// window is clipped to the source. Configuration writes are taken at once
// and are expected only while no word is in flight.
module rgb24_row_padded_crop (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [rgbcrop_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rgbcrop_pkg::CfgDataW-1:0] cfg_data_i,
  // source byte stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] src_byte
  input  wire logic        s_axis_tuser,   // [0] start_of_image
  // cropped byte stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,   // row_end
  output logic [1:0]       m_axis_tuser    // [0] is_padding, [1] image_end
);

  localparam int unsigned DimW = rgbcrop_pkg::DimW;
  localparam int unsigned OffW = rgbcrop_pkg::OffW;
  localparam int unsigned PosW = rgbcrop_pkg::PosW;

  // configuration registers
  logic [DimW-1:0] src_width_q, src_height_q, crop_w_q, crop_h_q;
  logic [OffW-1:0] crop_x_q, crop_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= DimW'(1);
      src_height_q <= DimW'(1);
      crop_x_q     <= '0;
      crop_y_q     <= '0;
      crop_w_q     <= DimW'(1);
      crop_h_q     <= DimW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rgbcrop_pkg::cfg_reg_e'(cfg_index_i))
        rgbcrop_pkg::CfgSrcWidth:  src_width_q  <= cfg_data_i;
        rgbcrop_pkg::CfgSrcHeight: src_height_q <= cfg_data_i;
        rgbcrop_pkg::CfgCropX:     crop_x_q     <= cfg_data_i[OffW-1:0];
        rgbcrop_pkg::CfgCropY:     crop_y_q     <= cfg_data_i[OffW-1:0];
        rgbcrop_pkg::CfgCropW:     crop_w_q     <= cfg_data_i;
        rgbcrop_pkg::CfgCropH:     crop_h_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped width, source stride and clipped window bounds
  logic [DimW-1:0] sw, xe, ye;
  logic [PosW-1:0] stride, x_sum, y_sum, xe3, x03;

  always_comb begin
    if (src_width_q == '0) begin
      sw = DimW'(1);
    end else if (src_width_q > DimW'(rgbcrop_pkg::MaxWidth)) begin
      sw = DimW'(rgbcrop_pkg::MaxWidth);
    end else begin
      sw = src_width_q;
    end
    // 3*w bytes plus padding; (-3w) mod 4 equals w mod 4
    stride = (PosW'(sw) << 1) + PosW'(sw) + PosW'(sw[1:0]);
    x_sum  = PosW'(crop_x_q) + PosW'(crop_w_q);
    y_sum  = PosW'(crop_y_q) + PosW'(crop_h_q);
    xe     = (x_sum < PosW'(sw)) ? x_sum[DimW-1:0] : sw;
    ye     = (y_sum < PosW'(src_height_q)) ? y_sum[DimW-1:0] : src_height_q;
    xe3    = (PosW'(xe) << 1) + PosW'(xe);
    x03    = (PosW'(crop_x_q) << 1) + PosW'(crop_x_q);
  end

  // position counters
  logic [PosW-1:0] byte_in_row_q, byte_in_row_d, pos;
  logic [DimW-1:0] row_index_q, row_index_d, row;
  logic            in_fire, keep, wrap;
  rgbcrop_pkg::res_t res_new;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pos  = s_axis_tuser ? '0 : byte_in_row_q;
    row  = s_axis_tuser ? '0 : row_index_q;
    keep = (row < src_height_q) && (row >= DimW'(crop_y_q)) && (row < ye) &&
           (DimW'(crop_x_q) < xe) && (pos >= x03) && (pos < xe3);
    wrap = ((PosW + 1)'(pos) + 1'b1) >= (PosW + 1)'(stride);

    byte_in_row_d = wrap ? '0 : pos + 1'b1;
    row_index_d   = (wrap && (row < src_height_q)) ? row + 1'b1 : row;

    res_new.data     = s_axis_tdata;
    res_new.row_last = ((PosW + 1)'(pos) + 1'b1) == (PosW + 1)'(xe3);
    // output row is 3*(xe-x) bytes, so its padding is (xe-x) mod 4
    res_new.pad      = res_new.row_last ? (xe[1:0] - crop_x_q[1:0]) : 2'd0;
    res_new.img_row  = ((DimW + 1)'(row) + 1'b1) == (DimW + 1)'(ye);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_in_row_q <= '0;
      row_index_q   <= '0;
    end else if (in_fire) begin
      byte_in_row_q <= byte_in_row_d;
      row_index_q   <= row_index_d;
    end
  end

  // result register and padding drain
  rgbcrop_pkg::res_t res_q;
  logic       res_valid_q, pad_phase_q;
  logic [1:0] pad_left_q;
  logic       out_fire, last_word;

  assign out_fire  = m_axis_tvalid && m_axis_tready;
  assign last_word = out_fire &&
                     (pad_phase_q ? (pad_left_q == 2'd1) : (res_q.pad == 2'd0));
  assign s_axis_tready = !res_valid_q || last_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      pad_phase_q <= 1'b0;
      pad_left_q  <= '0;
    end else if (in_fire && keep) begin
      res_valid_q <= 1'b1;
      pad_phase_q <= 1'b0;
      pad_left_q  <= '0;
    end else if (last_word) begin
      res_valid_q <= 1'b0;
      pad_phase_q <= 1'b0;
    end else if (out_fire) begin
      pad_phase_q <= 1'b1;
      pad_left_q  <= pad_phase_q ? pad_left_q - 1'b1 : res_q.pad;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && keep) begin
      res_q <= res_new;
    end
  end

  // output word select
  always_comb begin
    m_axis_tvalid = res_valid_q;
    if (pad_phase_q) begin
      m_axis_tdata = '0;
      m_axis_tlast = (pad_left_q == 2'd1);
    end else begin
      m_axis_tdata = res_q.data;
      m_axis_tlast = res_q.row_last && (res_q.pad == 2'd0);
    end
    m_axis_tuser = {m_axis_tlast && res_q.img_row, pad_phase_q};
  end

  // checks
  a_pad_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_phase_q |-> res_valid_q)
    else $error("padding phase without a pending result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_valid_q) |-> last_word)
    else $error("input accepted while result still draining");

  a_pad_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && pad_phase_q && pad_left_q != 2'd1) |=> (res_valid_q && pad_phase_q))
    else $error("padding run cut short");

  a_image_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
    else $error("image end not on a row end");

endmodule
`default_nettype wire
